// ===== rtl/ngfs_pkg.sv =====
package ngfs_pkg;

  // Field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FIELD_NUM_W = 6;
  localparam int unsigned HDR_LEN_W   = 3;
  localparam int unsigned HDR_PAT_W   = 48;
  localparam int unsigned HDR_CHARS   = 6;

  // Configuration port geometry
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Register reset values
  localparam logic [HDR_PAT_W-1:0] HDR_PATTERN_RST = 48'h24474E474741;
  localparam logic [HDR_LEN_W-1:0] HDR_LENGTH_RST  = 3'd6;
  localparam logic [BYTE_W-1:0]    MAX_LENGTH_RST  = 8'd100;

  // Special characters
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2c;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HDR_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd2;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_END_OK   = 2'd1,
    KIND_END_LONG = 2'd2
  } ngfs_kind_t;

  typedef struct packed {
    logic [HDR_PAT_W-1:0] hdr_pattern;
    logic [HDR_LEN_W-1:0] hdr_length;
    logic [BYTE_W-1:0]    max_length;
  } ngfs_cfg_t;

  typedef struct packed {
    ngfs_kind_t             kind;
    logic [FIELD_NUM_W-1:0] field_number;
    logic [BYTE_W-1:0]      char_position;
    logic [BYTE_W-1:0]      char_value;
    logic [BYTE_W-1:0]      sentence_length;
  } ngfs_result_t;

endpackage

// ===== rtl/nmea_gga_field_splitter.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_tvalid/tready   | tdata[7:0] rx_byte
// out_    | output    | out_tvalid/tready  | tuser kind; tdata field, position, char, length
// cfg_    | input     | psel/penable/ready | 64-bit registers at byte address 8*index
//
// One byte is taken every cycle while the queue has room; a result passes through
// the queue write and then the output register before it reaches out_tdata.
// Reset (synchronous, rst_n low) returns to header hunting and empties the queue.
// When out_tready stays low the queue of QUEUE_DEPTH entries and the output
// register fill, then in_tready drops; bytes that give no result wait for it as well.
module nmea_gga_field_splitter
  import ngfs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: [7:0] rx_byte
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: [5:0] field_number, [13:6] char_position, [21:14] char_value,
  //        [29:22] sentence_length, [31:30] zero
  output logic [31:0]           out_tdata,
  // tuser: [1:0] result_kind
  output logic [1:0]            out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  ngfs_cfg_t       cfg_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic            cfg_wr;
  logic            in_accept;
  logic            push;
  ngfs_result_t    push_data;
  logic            pop;
  ngfs_result_t    head;
  logic            not_empty;
  logic            not_full;

  // Register file
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_pattern <= HDR_PATTERN_RST;
      cfg_r.hdr_length  <= HDR_LENGTH_RST;
      cfg_r.max_length  <= MAX_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HDR_PATTERN: cfg_r.hdr_pattern <= cfg_pwdata[HDR_PAT_W-1:0];
        REG_HDR_LENGTH:  cfg_r.hdr_length  <= cfg_pwdata[HDR_LEN_W-1:0];
        REG_MAX_LENGTH:  cfg_r.max_length  <= cfg_pwdata[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HDR_PATTERN: cfg_prdata = CFG_DATA_W'(cfg_r.hdr_pattern);
      REG_HDR_LENGTH:  cfg_prdata = CFG_DATA_W'(cfg_r.hdr_length);
      REG_MAX_LENGTH:  cfg_prdata = CFG_DATA_W'(cfg_r.max_length);
      default:         cfg_prdata = '0;
    endcase
  end

  // Take a byte while the queue has room
  assign in_tready = not_full;
  assign in_accept = in_tvalid && in_tready;

  ngfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (in_accept),
    .rx_byte   (in_tdata),
    .push      (push),
    .push_data (push_data)
  );

  ngfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .not_full  (not_full)
  );

  ngfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/ngfs_front.sv =====
module ngfs_front
  import ngfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ngfs_cfg_t         cfg,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              push,
  output ngfs_result_t      push_data
);

  typedef enum logic [1:0] {
    ST_HUNT = 2'b01,
    ST_BODY = 2'b10
  } ngfs_state_t;

  ngfs_state_t            state_r, state_nxt;
  logic [HDR_LEN_W-1:0]   match_cnt_r, match_cnt_nxt;
  logic [FIELD_NUM_W-1:0] field_r, field_nxt;
  logic [BYTE_W-1:0]      pos_r, pos_nxt;
  logic [BYTE_W-1:0]      len_r, len_nxt;

  logic [HDR_LEN_W-1:0]   eff_len;
  logic [BYTE_W-1:0]      hdr_char;
  logic [BYTE_W-1:0]      len_inc;
  logic                   is_eol;

  // Clamp header length to one through six
  always_comb begin
    if (cfg.hdr_length == '0) begin
      eff_len = HDR_LEN_W'(1);
    end else if (cfg.hdr_length > HDR_LEN_W'(HDR_CHARS)) begin
      eff_len = HDR_LEN_W'(HDR_CHARS);
    end else begin
      eff_len = cfg.hdr_length;
    end
  end

  // Select the expected header character, first one in the top byte
  always_comb begin
    unique case (match_cnt_r)
      3'd0:    hdr_char = cfg.hdr_pattern[47:40];
      3'd1:    hdr_char = cfg.hdr_pattern[39:32];
      3'd2:    hdr_char = cfg.hdr_pattern[31:24];
      3'd3:    hdr_char = cfg.hdr_pattern[23:16];
      3'd4:    hdr_char = cfg.hdr_pattern[15:8];
      3'd5:    hdr_char = cfg.hdr_pattern[7:0];
      3'd6:    hdr_char = cfg.hdr_pattern[47:40];
      default: hdr_char = cfg.hdr_pattern[39:32];
    endcase
  end

  assign is_eol  = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
  assign len_inc = (len_r == '1) ? len_r : len_r + BYTE_W'(1);

  // Classify the byte and advance the sentence counters
  always_comb begin
    state_nxt     = state_r;
    match_cnt_nxt = match_cnt_r;
    field_nxt     = field_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    push          = 1'b0;
    push_data     = '{kind: KIND_CHAR, field_number: field_r, char_position: pos_r,
                      char_value: rx_byte, sentence_length: len_inc};
    if (accept) begin
      unique case (state_r)
        ST_HUNT: begin
          if ((match_cnt_r < eff_len) && (rx_byte == hdr_char)) begin
            if (match_cnt_r + HDR_LEN_W'(1) >= eff_len) begin
              match_cnt_nxt = '0;
              state_nxt     = ST_BODY;
              field_nxt     = '0;
              pos_nxt       = '0;
              len_nxt       = '0;
            end else begin
              match_cnt_nxt = match_cnt_r + HDR_LEN_W'(1);
            end
          end else begin
            match_cnt_nxt = '0;
          end
        end
        ST_BODY: begin
          if (is_eol) begin
            push                      = 1'b1;
            push_data.kind            = (len_r < cfg.max_length) ? KIND_END_OK
                                                                 : KIND_END_LONG;
            push_data.char_value      = '0;
            push_data.sentence_length = len_r;
            state_nxt                 = ST_HUNT;
            match_cnt_nxt             = '0;
            field_nxt                 = '0;
            pos_nxt                   = '0;
            len_nxt                   = '0;
          end else if (rx_byte == CHAR_COMMA) begin
            len_nxt   = len_inc;
            field_nxt = (field_r == '1) ? field_r : field_r + FIELD_NUM_W'(1);
            pos_nxt   = '0;
          end else begin
            push    = 1'b1;
            len_nxt = len_inc;
            pos_nxt = (pos_r == '1) ? pos_r : pos_r + BYTE_W'(1);
          end
        end
        default: begin
          state_nxt = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      match_cnt_r <= '0;
      field_r     <= '0;
      pos_r       <= '0;
      len_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      match_cnt_r <= match_cnt_nxt;
      field_r     <= field_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
    end
  end

endmodule

// ===== rtl/ngfs_queue.sv =====
module ngfs_queue
  import ngfs_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  ngfs_result_t push_data,
  input  logic         pop,
  output ngfs_result_t head,
  output logic         not_empty,
  output logic         not_full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ngfs_result_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign not_full  = (count_r < CNT_W'(DEPTH));
  assign head      = mem[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/ngfs_back.sv =====
module ngfs_back
  import ngfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ngfs_result_t head,
  input  logic         head_valid,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,
  output logic [1:0]   out_tuser
);

  logic         valid_r;
  ngfs_result_t data_r;

  // Reload the output register whenever it is empty or being drained
  assign pop = head_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = data_r.kind;
  assign out_tdata  = {2'b00, data_r.sentence_length, data_r.char_value,
                       data_r.char_position, data_r.field_number};

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import ngfs_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One row of the directed table: a byte and, where typed, its expected result
  typedef struct packed {
    logic [7:0]   rx;
    logic         typed;
    ngfs_result_t want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [27] = '{
    // empty sentence right after the header
    '{"$", 1'b0, '0}, '{"G", 1'b0, '0}, '{"N", 1'b0, '0},
    '{"G", 1'b0, '0}, '{"G", 1'b0, '0}, '{"A", 1'b0, '0},
    '{CHAR_LF, 1'b1, '{KIND_END_OK, 6'd0, 8'd0, 8'd0, 8'd0}},
    // a mismatch restarts the hunt without retesting the byte, so Z stays silent
    '{"$", 1'b0, '0}, '{"$", 1'b0, '0}, '{"G", 1'b0, '0}, '{"N", 1'b0, '0},
    '{"G", 1'b0, '0}, '{"G", 1'b0, '0}, '{"A", 1'b0, '0}, '{"Z", 1'b0, '0},
    // payload with a comma, NUL, all-ones and a header character inside
    '{"$", 1'b0, '0}, '{"G", 1'b0, '0}, '{"N", 1'b0, '0},
    '{"G", 1'b0, '0}, '{"G", 1'b0, '0}, '{"A", 1'b0, '0},
    '{"A", 1'b1, '{KIND_CHAR, 6'd0, 8'd0, "A", 8'd1}},
    '{CHAR_COMMA, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_CHAR, 6'd1, 8'd0, 8'h00, 8'd3}},
    '{8'hff, 1'b1, '{KIND_CHAR, 6'd1, 8'd1, 8'hff, 8'd4}},
    '{"$", 1'b1, '{KIND_CHAR, 6'd1, 8'd2, "$", 8'd5}},
    '{CHAR_CR, 1'b1, '{KIND_END_OK, 6'd1, 8'd3, 8'd0, 8'd5}}
  };

  // Over-long sentence at limit 255: field number and sentence length saturated
  localparam ngfs_result_t SATURATED_END = '{KIND_END_LONG, 6'd63, 8'd1, 8'd0, 8'd255};

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [31:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  nmea_gga_field_splitter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Shadow registers
  logic [HDR_PAT_W-1:0] hdr_pattern = HDR_PATTERN_RST;
  logic [HDR_LEN_W-1:0] hdr_length  = HDR_LENGTH_RST;
  logic [BYTE_W-1:0]    max_length  = MAX_LENGTH_RST;

  // Splitter state
  int unsigned            match_count = 0;
  logic                   in_sentence = 1'b0;
  logic [FIELD_NUM_W-1:0] field_count = '0;
  logic [BYTE_W-1:0]      field_pos   = '0;
  logic [BYTE_W-1:0]      payload_len = '0;

  ngfs_result_t field_results[$];
  int unsigned  mismatches     = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  sentence_bytes = 0;
  bit           in_burst       = 1'b0;
  bit           out_burst      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned hdr_chars_used();
    if (hdr_length == 0) return 1;
    if (hdr_length > HDR_CHARS) return HDR_CHARS;
    return 32'(hdr_length);
  endfunction

  function automatic logic [7:0] hdr_char(input int unsigned idx);
    return hdr_pattern[HDR_PAT_W - 1 - 8 * idx -: 8];
  endfunction

  // Advance the splitter by one byte; return 1 with the result if it makes one
  function automatic logic split_byte(input logic [7:0] b, output ngfs_result_t res);
    res = '0;
    if (!in_sentence) begin
      if (match_count < hdr_chars_used() && b == hdr_char(match_count)) begin
        match_count++;
        if (match_count >= hdr_chars_used()) begin
          match_count = 0;
          in_sentence = 1'b1;
          field_count = '0;
          field_pos   = '0;
          payload_len = '0;
        end
      end else begin
        match_count = 0;
      end
      return 1'b0;
    end
    // close the sentence on a line end
    if (b == CHAR_CR || b == CHAR_LF) begin
      res.kind            = (payload_len < max_length) ? KIND_END_OK : KIND_END_LONG;
      res.field_number    = field_count;
      res.char_position   = field_pos;
      res.sentence_length = payload_len;
      in_sentence = 1'b0;
      match_count = 0;
      field_count = '0;
      field_pos   = '0;
      payload_len = '0;
      return 1'b1;
    end
    if (payload_len != 8'hff) payload_len++;
    if (b == CHAR_COMMA) begin
      if (field_count != 6'h3f) field_count++;
      field_pos = '0;
      return 1'b0;
    end
    res.kind            = KIND_CHAR;
    res.field_number    = field_count;
    res.char_position   = field_pos;
    res.char_value      = b;
    res.sentence_length = payload_len;
    if (field_pos != 8'hff) field_pos++;
    return 1'b1;
  endfunction

  // Offer one byte after a random gap and record what it should produce
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input ngfs_result_t want = '0);
    int unsigned  gap;
    logic         taken;
    logic         has_result;
    ngfs_result_t predicted;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do begin
      @(negedge clk);
      taken = (in_tready === 1'b1);
      if (taken) begin
        if (in_sentence) sentence_bytes++;
        has_result = split_byte(b, predicted);
        if (typed) field_results.push_back(want);
        else if (has_result) field_results.push_back(predicted);
      end
      @(posedge clk);
    end while (!taken);
  endtask

  // Hold the sender until every expected result has come, then settle
  task automatic await_drain(input int unsigned settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (field_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic rdy;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 3'b000});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = (cfg_pready === 1'b1);
      @(posedge clk);
    end while (!rdy);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_HDR_PATTERN: hdr_pattern = value[HDR_PAT_W-1:0];
      REG_HDR_LENGTH:  hdr_length  = value[HDR_LEN_W-1:0];
      REG_MAX_LENGTH:  max_length  = value[BYTE_W-1:0];
      default: ;
    endcase
    // idle between transactions
    @(posedge clk);
  endtask

  // Write all three registers with junk in the unused upper bits
  task automatic load_config(input logic [HDR_PAT_W-1:0] pat, input logic [HDR_LEN_W-1:0] len,
                             input logic [BYTE_W-1:0] lim);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_HDR_PATTERN, {junk[63:48], pat});
    write_reg(REG_HDR_LENGTH, {junk[63:3], len});
    write_reg(REG_MAX_LENGTH, {junk[63:8], lim});
  endtask

  // Mostly well-formed sentences with random content, some broken headers and noise
  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int unsigned n_fields;
    int unsigned f_len;
    int unsigned n;
    int unsigned i;
    int unsigned j;
    logic [7:0]  c;
    stop_at = sentence_bytes + quota;
    while (sentence_bytes < stop_at) begin
      if ($urandom_range(0, 7) == 0) in_burst = !in_burst;
      if ($urandom_range(0, 29) == 0) await_drain(0);
      case ($urandom_range(0, 9))
        7: begin
          // header cut short by a stray byte
          n = $urandom_range(0, hdr_chars_used() - 1);
          for (i = 0; i < n; i++) send_byte(hdr_char(i));
          send_byte(8'($urandom_range(0, 255)));
        end
        8, 9: begin
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          for (i = 0; i < hdr_chars_used(); i++) send_byte(hdr_char(i));
          n_fields = $urandom_range(0, 14);
          for (i = 0; i <= n_fields; i++) begin
            f_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            for (j = 0; j < f_len; j++) begin
              case ($urandom_range(0, 15))
                0, 1: begin
                  c = 8'($urandom_range(0, 255));
                  if (c == CHAR_CR || c == CHAR_LF) c ^= 8'h80;
                end
                2: c = hdr_char($urandom_range(0, HDR_CHARS - 1));
                default: c = 8'($urandom_range(8'h2d, 8'h5a));
              endcase
              send_byte(c);
            end
            if (i != n_fields) send_byte(CHAR_COMMA);
          end
          case ($urandom_range(0, 11))
            0: ;  // leave the sentence open
            1, 2, 3, 4: send_byte(CHAR_CR);
            5, 6, 7, 8: send_byte(CHAR_LF);
            default: begin
              send_byte(CHAR_CR);
              send_byte(CHAR_LF);
            end
          endcase
        end
      endcase
    end
  endtask

  // Result side: random stalls, with bursts of constant readiness
  initial begin : take_results
    int unsigned gap;
    logic        took;
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        took = (out_tvalid === 1'b1);
        @(posedge clk);
      end while (!took);
    end
  end

  // Check each result transaction against the oldest expectation; watch for a hang
  always @(negedge clk) begin : check_results
    ngfs_result_t want;
    logic         out_fire;
    out_fire = (out_tvalid === 1'b1) && (out_tready === 1'b1);
    if (rst_n) begin
      if (out_fire) begin
        if (field_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: kind %0d tdata %08h", out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = field_results.pop_front();
          if (out_tuser !== want.kind || out_tdata[5:0] !== want.field_number ||
              out_tdata[13:6] !== want.char_position ||
              out_tdata[21:14] !== want.char_value ||
              out_tdata[29:22] !== want.sentence_length || out_tdata[31:30] !== 2'b00) begin
            if (mismatches < 10)
              $display("mismatch: expected kind %0d field %0d pos %0d char %02h len %0d, %s",
                       want.kind, want.field_number, want.char_position, want.char_value,
                       want.sentence_length, "got");
            if (mismatches < 10)
              $display("          actual   kind %0d field %0d pos %0d char %02h len %0d pad %0d",
                       out_tuser, out_tdata[5:0], out_tdata[13:6], out_tdata[21:14],
                       out_tdata[29:22], out_tdata[31:30]);
            mismatches++;
          end
        end
      end
      if (out_fire || ((in_tvalid === 1'b1) && (in_tready === 1'b1))) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    logic [7:0]  b;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset settings
    foreach (DIRECTED[k]) send_byte(DIRECTED[k].rx, DIRECTED[k].typed, DIRECTED[k].want);
    run_random(190);

    // Random header, length zero acts as one, limit zero rejects everything
    await_drain(SETTLE_CYCLES);
    load_config(HDR_PAT_W'({$urandom, $urandom}), 3'd0, 8'd0);
    run_random(150);

    // All-ones header, length seven acts as six, limit 255
    await_drain(SETTLE_CYCLES);
    load_config('1, 3'd7, 8'd255);
    // close any open sentence, then drive every counter into saturation
    send_byte(CHAR_CR);
    for (i = 0; i < HDR_CHARS; i++) send_byte(hdr_char(i));
    for (i = 0; i < 270; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_COMMA || b == CHAR_CR || b == CHAR_LF);
      send_byte(b);
    end
    repeat (66) send_byte(CHAR_COMMA);
    send_byte("x");
    send_byte(CHAR_CR, 1'b1, SATURATED_END);
    run_random(90);

    // Single NUL header, limit one accepts only empty sentences
    await_drain(SETTLE_CYCLES);
    load_config('0, 3'd1, 8'd1);
    run_random(145);

    // Write past the register map, then a short header and a random limit
    await_drain(SETTLE_CYCLES);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    load_config(HDR_PATTERN_RST, 3'd3, 8'($urandom_range(1, 254)));
    run_random(145);

    await_drain(16);
    if (mismatches == 0 && field_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== nmea_gga_field_splitter.f =====
rtl/ngfs_pkg.sv
rtl/ngfs_front.sv
rtl/ngfs_queue.sv
rtl/ngfs_back.sv
rtl/nmea_gga_field_splitter.sv
sim/testbench.sv
